[sv/sbm_pkg.sv]
// Shared types and constants for the string-break minimum-cost block.
// No dependencies; every other file but sbm_ram imports this package.
package sbm_pkg;

  localparam int unsigned POS_W    = 7;
  localparam int unsigned COST_W   = 13;
  localparam int unsigned Q_W      = 15;
  localparam int unsigned SL_W     = 8;
  localparam logic [COST_W-1:0] COST_SAT = 13'd8191;
  localparam logic [SL_W-1:0] SL_RESET = 8'd128;

  localparam int unsigned MAX_LEN_DEF  = 128;
  localparam int unsigned MAX_CUTS_DEF = 32;

  localparam logic REC_COST = 1'b0;
  localparam logic REC_CUT  = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEG, ST_KRD, ST_KCHK, ST_KCMP, ST_WR, ST_ROOT, ST_COST,
    ST_POP, ST_POPD, ST_KRD2, ST_KIDS, ST_PUSHL
  } state_e;

  typedef enum logic [1:0] {
    SEL_SPLIT, SEL_ROOT, SEL_KIDS
  } addr_sel_e;

  typedef struct packed {
    logic      load;
    logic      seg_first;
    logic      seg_start;
    logic      k_next;
    logic      k_cmp;
    logic      seg_wr;
    logic      cnt_clr;
    addr_sel_e sel;
    logic      emit_cost;
    logic      pop;
    logic      grab;
    logic      emit_cut;
    logic      push_r;
    logic      push_l;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic cnt_zero;
    logic in_rng;
    logic k_last;
    logic seg_last;
    logic sp_zero;
    logic out_free;
  } sts_t;

endpackage

[sv/sbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sbm_ctrl.sv]
// Sequencer for load, interval DP and split-tree walk.
// Depends on sbm_pkg; drives the datapath through cmd_t, reads sts_t.
module sbm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_cut_i,
  output logic          in_ready_o,
  input  sbm_pkg::sts_t sts_i,
  output sbm_pkg::cmd_t cmd_o
);
  import sbm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && last_cut_i) begin
          state_d = sts_i.n_small ? ST_ROOT : ST_SEG;
        end
      end
      ST_SEG:  state_d = sts_i.cnt_zero ? ST_WR : ST_KRD;
      ST_KRD:  state_d = ST_KCHK;
      ST_KCHK: begin
        if (sts_i.in_rng) state_d = ST_KCMP;
        else state_d = sts_i.k_last ? ST_WR : ST_KRD;
      end
      ST_KCMP: state_d = sts_i.k_last ? ST_WR : ST_KRD;
      ST_WR:   state_d = sts_i.seg_last ? ST_ROOT : ST_SEG;
      ST_ROOT: state_d = ST_COST;
      ST_COST: if (sts_i.out_free) state_d = ST_POP;
      ST_POP:  state_d = sts_i.sp_zero ? ST_LOAD : ST_POPD;
      ST_POPD: state_d = ST_KRD2;
      ST_KRD2: state_d = ST_KIDS;
      ST_KIDS: if (sts_i.out_free) state_d = ST_PUSHL;
      ST_PUSHL: state_d = ST_POP;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_SPLIT;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o      = 1'b1;
        cmd_o.load      = in_valid_i;
        cmd_o.seg_first = in_valid_i && last_cut_i;
      end
      ST_SEG:  cmd_o.seg_start = 1'b1;
      ST_KRD:  ;
      ST_KCHK: cmd_o.k_next = !sts_i.in_rng && !sts_i.k_last;
      ST_KCMP: begin
        cmd_o.k_cmp  = 1'b1;
        cmd_o.k_next = !sts_i.k_last;
      end
      ST_WR:   cmd_o.seg_wr = 1'b1;
      ST_ROOT: begin
        cmd_o.sel     = SEL_ROOT;
        cmd_o.cnt_clr = 1'b1;
      end
      ST_COST: begin
        cmd_o.sel       = SEL_ROOT;
        cmd_o.emit_cost = sts_i.out_free;
      end
      ST_POP:  cmd_o.pop = !sts_i.sp_zero;
      ST_POPD: cmd_o.grab = 1'b1;
      ST_KRD2: cmd_o.sel = SEL_KIDS;
      ST_KIDS: begin
        cmd_o.sel      = SEL_KIDS;
        cmd_o.emit_cut = sts_i.out_free;
        cmd_o.push_r   = sts_i.out_free;
      end
      ST_PUSHL: begin
        cmd_o.sel    = SEL_KIDS;
        cmd_o.push_l = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[sv/sbm_dp.sv]
// Datapath: cut store, segment table, walk stack and result register.
// Depends on sbm_pkg and sbm_ram; steered by sbm_ctrl via cmd_t.
module sbm_dp #(
  parameter int unsigned MAX_LEN  = sbm_pkg::MAX_LEN_DEF,
  parameter int unsigned MAX_CUTS = sbm_pkg::MAX_CUTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sbm_pkg::cmd_t               cmd_i,
  output sbm_pkg::sts_t               sts_o,
  input  logic [sbm_pkg::SL_W-1:0]    string_length_i,
  input  logic [sbm_pkg::POS_W-1:0]   cut_position_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        record_type_o,
  output logic [sbm_pkg::COST_W-1:0]  result_value_o,
  output logic                        end_of_run_o
);
  import sbm_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_LEN);
  localparam int unsigned NW  = $clog2(MAX_LEN + 1);
  localparam int unsigned XW  = (NW > POS_W) ? NW : POS_W;
  localparam int unsigned AW  = 2 * LW;
  localparam int unsigned TD  = 1 << AW;
  localparam int unsigned TW  = COST_W + POS_W;
  localparam int unsigned CW  = $clog2(MAX_CUTS + 1);
  localparam int unsigned CAW = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
  localparam int unsigned SD  = MAX_CUTS + 1;
  localparam int unsigned SPW = $clog2(SD + 1);
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned EW  = 2 * LW + POS_W;

  // effective length
  logic [NW-1:0] n;
  always_comb begin
    if (32'(string_length_i) > MAX_LEN) n = NW'(MAX_LEN);
    else n = NW'(string_length_i);
  end

  // cut store
  logic [CW-1:0]    cnt_q;
  logic [CAW-1:0]   k_q;
  logic [POS_W-1:0] p;
  logic             cut_ok;

  assign cut_ok = (cut_position_i != '0) && (XW'(cut_position_i) < XW'(n)) &&
                  (cnt_q < CW'(MAX_CUTS));

  sbm_ram #(.WIDTH(POS_W), .DEPTH(MAX_CUTS)) u_cut (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && cut_ok),
    .waddr_i (cnt_q[CAW-1:0]),
    .wdata_i (cut_position_i),
    .raddr_i (k_q),
    .rdata_o (p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.load && cut_ok) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // segment loop
  logic [NW-1:0]    len_q, i_q, j;
  logic [Q_W-1:0]   best_q, q;
  logic             have_q;
  logic [POS_W-1:0] pick_q;
  logic [TW-1:0]    ra, rb;
  logic [COST_W-1:0] wr_cost;

  assign j = i_q + len_q - NW'(1);
  assign q = Q_W'(len_q) + Q_W'(ra[TW-1:POS_W]) + Q_W'(rb[TW-1:POS_W]);
  assign wr_cost = (best_q > Q_W'(COST_SAT)) ? COST_SAT : best_q[COST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_first) begin
      len_q <= NW'(1);
      i_q   <= NW'(1);
    end else if (cmd_i.seg_wr) begin
      if (j == n) begin
        len_q <= len_q + NW'(1);
        i_q   <= NW'(1);
      end else begin
        i_q <= i_q + NW'(1);
      end
    end
    if (cmd_i.seg_start) begin
      k_q    <= '0;
      have_q <= 1'b0;
      best_q <= '0;
      pick_q <= '0;
    end else begin
      if (cmd_i.k_next) k_q <= k_q + CAW'(1);
      if (cmd_i.k_cmp && (!have_q || q < best_q)) begin
        have_q <= 1'b1;
        best_q <= q;
        pick_q <= p;
      end
    end
  end

  // walk stack
  logic [SPW-1:0]   sp_q, sp_d;
  logic [EW-1:0]    ent_q, stk_rdata, stk_wdata;
  logic             stk_we;
  logic [LW-1:0]    ent_lo, ent_hi;
  logic [POS_W-1:0] ent_p, pr, pl;

  assign ent_lo = ent_q[EW-1 -: LW];
  assign ent_hi = ent_q[POS_W +: LW];
  assign ent_p  = ent_q[POS_W-1:0];
  assign pr     = ra[POS_W-1:0];
  assign pl     = rb[POS_W-1:0];

  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = {ent_lo, LW'(ent_p - POS_W'(1)), pl};
    sp_d      = sp_q;
    priority if (cmd_i.emit_cost) begin
      stk_wdata = {LW'(0), LW'(n - NW'(1)), pr};
      stk_we    = !sts_o.n_small && (pr != '0);
    end else if (cmd_i.push_r) begin
      stk_wdata = {LW'(ent_p), ent_hi, pr};
      stk_we    = (pr != '0);
    end else if (cmd_i.push_l) begin
      stk_we    = (pl != '0);
    end else if (cmd_i.pop) begin
      sp_d = sp_q - SPW'(1);
    end else begin
      sp_d = sp_q;
    end
    if (stk_we) sp_d = sp_q + SPW'(1);
  end

  sbm_ram #(.WIDTH(EW), .DEPTH(SD)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q[SAW-1:0]),
    .wdata_i (stk_wdata),
    .raddr_i (SAW'(sp_q - SPW'(1))),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grab) ent_q <= stk_rdata;
  end

  // segment table, duplicated for two reads per cycle
  logic [AW-1:0] raddr_a, raddr_b, waddr;

  assign waddr = {LW'(i_q - NW'(1)), LW'(j - NW'(1))};

  always_comb begin
    unique case (cmd_i.sel)
      SEL_ROOT: begin
        raddr_a = {LW'(0), LW'(n - NW'(1))};
        raddr_b = raddr_a;
      end
      SEL_KIDS: begin
        raddr_a = {LW'(ent_p), ent_hi};
        raddr_b = {ent_lo, LW'(ent_p - POS_W'(1))};
      end
      default: begin
        raddr_a = {LW'(i_q - NW'(1)), LW'(p - POS_W'(1))};
        raddr_b = {LW'(p), LW'(j - NW'(1))};
      end
    endcase
  end

  sbm_ram #(.WIDTH(TW), .DEPTH(TD)) u_tbl_a (
    .clk_i (clk_i), .we_i (cmd_i.seg_wr), .waddr_i (waddr),
    .wdata_i ({wr_cost, pick_q}), .raddr_i (raddr_a), .rdata_o (ra)
  );

  sbm_ram #(.WIDTH(TW), .DEPTH(TD)) u_tbl_b (
    .clk_i (clk_i), .we_i (cmd_i.seg_wr), .waddr_i (waddr),
    .wdata_i ({wr_cost, pick_q}), .raddr_i (raddr_b), .rdata_o (rb)
  );

  // result register
  logic              out_valid_q, out_type_q, out_end_q;
  logic [COST_W-1:0] out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_cost || cmd_i.emit_cut) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_cost) begin
      out_type_q <= REC_COST;
      out_val_q  <= sts_o.n_small ? '0 : ra[TW-1:POS_W];
      out_end_q  <= sts_o.n_small || (pr == '0);
    end else if (cmd_i.emit_cut) begin
      out_type_q <= REC_CUT;
      out_val_q  <= COST_W'(ent_p);
      out_end_q  <= (sp_q == '0) && (pr == '0) && (pl == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_type_o  = out_type_q;
  assign result_value_o = out_val_q;
  assign end_of_run_o   = out_end_q;

  // status
  assign sts_o.n_small  = (n <= NW'(1));
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.in_rng   = (XW'(i_q) <= XW'(p)) && (XW'(p) < XW'(j));
  assign sts_o.k_last   = (CW'(k_q) == cnt_q - CW'(1));
  assign sts_o.seg_last = (j == n) && (len_q == n);
  assign sts_o.sp_zero  = (sp_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(SD))
    else $error("walk stack overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_CUTS))
    else $error("cut count overflow");

  a_push_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |-> (stk_wdata[POS_W-1:0] != '0))
    else $error("unsplit segment pushed");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_cost || cmd_i.emit_cut) |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten");

endmodule

[sv/string_break_min_cost.sv]
// Top level of the string-break minimum-cost block: APB register, sequencer
// and datapath. Depends on sbm_pkg, sbm_ctrl, sbm_dp (and sbm_ram below it).
//
//   channel | direction | handshake             | words
//   in      | input     | in_valid_i/in_ready_o | cut_position_i, last_cut_i
//   out     | output    | out_valid_o/out_ready_i | record_type_o, result_value_o,
//           |           |                       | end_of_run_o
//   apb     | input     | psel/penable/pready   | string_length at 0x0
//
// Cut words are taken one per cycle in the load state. After the last one
// the DP visits every segment of the n-character string, reading each stored
// cut in turn and comparing those that lie inside it, bound by the single
// cut-store read port. The walk then sends the cost word and one cut word per
// split, in preorder.
// Reset zeroes the cut count and stack pointer; no clearing pass is needed.
// A stalled output holds the walk; input is taken only while loading.
module string_break_min_cost #(
  parameter int unsigned MAX_LEN  = sbm_pkg::MAX_LEN_DEF,
  parameter int unsigned MAX_CUTS = sbm_pkg::MAX_CUTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sbm_pkg::POS_W-1:0]   cut_position_i,
  input  logic                        last_cut_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        record_type_o,
  output logic [sbm_pkg::COST_W-1:0]  result_value_o,
  output logic                        end_of_run_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sbm_pkg::*;

  logic [SL_W-1:0] string_length_q;
  cmd_t            cmd;
  sts_t            sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(string_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      string_length_q <= SL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      string_length_q <= pwdata[SL_W-1:0];
    end
  end

  sbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_cut_i (last_cut_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbm_dp #(.MAX_LEN(MAX_LEN), .MAX_CUTS(MAX_CUTS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .string_length_i (string_length_q),
    .cut_position_i  (cut_position_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .record_type_o   (record_type_o),
    .result_value_o  (result_value_o),
    .end_of_run_o    (end_of_run_o)
  );

endmodule

[test/string_break_min_cost_checker.sv]
// Checker for string_break_min_cost: watches the cut and result channels,
// predicts cost and split order, and compares. Depends on sbm_pkg.
`timescale 1ns / 1ps
module string_break_min_cost_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [sbm_pkg::POS_W-1:0]  cut_position_i,
  input  logic                       last_cut_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       record_type_i,
  input  logic [sbm_pkg::COST_W-1:0] result_value_i,
  input  logic                       end_of_run_i,
  input  logic [7:0]                 string_length_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import sbm_pkg::*;

  localparam int MaxLen  = 128;
  localparam int MaxCuts = 32;

  typedef struct packed {
    logic              rtype;
    logic [COST_W-1:0] value;
    logic              eor;
  } rec_t;

  rec_t            expected_q[$];
  logic [POS_W-1:0] cuts[MaxCuts];
  int               num_cuts;
  int unsigned      seg_cost[MaxLen+1][MaxLen+1];
  int unsigned      seg_pick[MaxLen+1][MaxLen+1];

  task automatic report(input string what);
    fail_count_o++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic add_rec(input logic t, input int unsigned v);
    rec_t r;
    r.rtype = t;
    r.value = v[COST_W-1:0];
    r.eor   = 1'b0;
    expected_q.push_back(r);
  endtask

  // Interval DP, then preorder walk of the split tree.
  task automatic solve_and_walk(input int n);
    int          j, p, sp, lo, hi, emitted, first;
    int unsigned q, best, pick;
    bit          have;
    int          stk_lo[MaxCuts+1];
    int          stk_hi[MaxCuts+1];
    first = expected_q.size();
    for (int len = 1; len <= n; len++) begin
      for (int i = 1; i + len - 1 <= n; i++) begin
        j = i + len - 1;
        best = 0; pick = 0; have = 0;
        for (int k = 0; k < num_cuts; k++) begin
          p = cuts[k];
          if (p >= i && p < j) begin
            q = len + seg_cost[i][p] + seg_cost[p+1][j];
            if (!have || q < best) begin
              have = 1; best = q; pick = p;
            end
          end
        end
        if (best > 8191) best = 8191;
        seg_cost[i][j] = best;
        seg_pick[i][j] = pick;
      end
    end
    add_rec(REC_COST, n >= 1 ? seg_cost[1][n] : 0);
    emitted = 1;
    sp = 0;
    if (n >= 2 && seg_pick[1][n] != 0) begin
      stk_lo[0] = 1; stk_hi[0] = n; sp = 1;
    end
    while (sp > 0 && emitted < MaxCuts + 1) begin
      sp--;
      lo = stk_lo[sp]; hi = stk_hi[sp];
      p = seg_pick[lo][hi];
      add_rec(REC_CUT, p);
      emitted++;
      if (p + 1 < hi && sp < MaxCuts + 1 && seg_pick[p+1][hi] != 0) begin
        stk_lo[sp] = p + 1; stk_hi[sp] = hi; sp++;
      end
      if (lo < p && sp < MaxCuts + 1 && seg_pick[lo][p] != 0) begin
        stk_lo[sp] = lo; stk_hi[sp] = p; sp++;
      end
    end
    expected_q[expected_q.size()-1].eor = 1'b1;
    if (first < 0) fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int   n;
    rec_t e;
    if (!rst_ni) begin
      num_cuts     <= 0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        n = string_length_i > MaxLen ? MaxLen : string_length_i;
        if (cut_position_i >= 1 && cut_position_i < n && num_cuts < MaxCuts) begin
          cuts[num_cuts] = cut_position_i;
          num_cuts = num_cuts + 1;
        end
        if (last_cut_i) begin
          solve_and_walk(n);
          num_cuts = 0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected word type=%0d value=%0d", record_type_i,
                           result_value_i));
        end else begin
          e = expected_q.pop_front();
          if (record_type_i !== e.rtype)
            report($sformatf("record_type %0d, want %0d", record_type_i, e.rtype));
          if (result_value_i !== e.value)
            report($sformatf("result_value %0d, want %0d", result_value_i, e.value));
          if (end_of_run_i !== e.eor)
            report($sformatf("end_of_run %0d, want %0d", end_of_run_i, e.eor));
        end
      end
    end
    pending_o <= expected_q.size();
  end
endmodule

[test/string_break_min_cost_tb.sv]
// Testbench top for string_break_min_cost: clock, reset, APB writes and cut
// stimulus. Depends on sbm_pkg, the block and string_break_min_cost_checker.
`timescale 1ns / 1ps
module string_break_min_cost_tb;
  import sbm_pkg::*;

  localparam longint CycleLimit = 64'd40_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [POS_W-1:0]  cut_position_i = '0;
  logic              last_cut_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              record_type_o;
  logic [COST_W-1:0] result_value_o;
  logic              end_of_run_o;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic [7:0]        string_length = 8'd128;
  int                fail_count, pending;
  int                send_idle, recv_stall;
  longint            cycles = 0;

  always #5 clk_i = ~clk_i;

  string_break_min_cost uut (.*);

  string_break_min_cost_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cut_position_i,
    .last_cut_i, .out_valid_i(out_valid_o), .out_ready_i, .record_type_i(record_type_o),
    .result_value_i(result_value_o), .end_of_run_i(end_of_run_o),
    .string_length_i(string_length), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_length(input logic [7:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    string_length = v;
  endtask

  // Valid stays high after a word is taken; the next call either drives the
  // next word or drops valid, so valid is written once per time step.
  task automatic send_cut(input logic [POS_W-1:0] pos, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cut_position_i <= pos;
    last_cut_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One job: mostly in-range cuts, a few out of range or repeated.
  task automatic random_job(input int ncuts);
    int n;
    logic [POS_W-1:0] p;
    n = string_length;
    for (int k = 0; k < ncuts; k++) begin
      if ($urandom_range(9) == 0 || n < 2) p = POS_W'($urandom);
      else p = POS_W'($urandom_range(n - 1, 1));
      send_cut(p, k == ncuts - 1);
    end
  endtask

  initial begin
    send_idle = 0; recv_stall = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: reset length, extremes, out-of-range, repeats.
    send_cut(7'd0, 1'b0);
    send_cut(7'd127, 1'b0);
    send_cut(7'd1, 1'b0);
    send_cut(7'd64, 1'b0);
    send_cut(7'd64, 1'b1);
    drain();
    send_cut(7'd0, 1'b1);
    drain();
    write_length(8'd2);
    send_cut(7'd1, 1'b0);
    send_cut(7'd2, 1'b1);
    drain();
    write_length(8'd10);
    send_cut(7'd2, 1'b0);
    send_cut(7'd8, 1'b0);
    send_cut(7'd5, 1'b0);
    send_cut(7'd9, 1'b0);
    send_cut(7'd10, 1'b1);
    drain();
    write_length(8'd0);
    send_cut(7'd85, 1'b1);
    drain();
    write_length(8'd255);
    for (int k = 0; k < 34; k++) send_cut(7'(k * 3 + 1), k == 33);
    drain();
    // Random phases with different idle mixes and lengths.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 84; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 84; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      write_length(ph == 0 ? 8'd128 : 8'($urandom_range(40, 2)));
      for (int j = 0; j < 6; j++) begin
        random_job($urandom_range(10, 1));
        if (j == 2) drain();
      end
      drain();
    end
    send_idle = 0; recv_stall = 0;
    drain();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

[files.f]
sv/sbm_pkg.sv
sv/sbm_ram.sv
sv/sbm_ctrl.sv
sv/sbm_dp.sv
sv/string_break_min_cost.sv
test/string_break_min_cost_checker.sv
test/string_break_min_cost_tb.sv
